### src/rat_pkg.sv
`default_nettype none

package rat_pkg;

    localparam int unsigned REGIONS_DEF    = 64;
    localparam int unsigned WORD_BYTES_DEF = 8;

    localparam int unsigned TYPE_W   = 3;
    localparam int unsigned RADDR_W  = 64;
    localparam int unsigned VADDR_W  = 32;
    localparam int unsigned SIZE_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned ENTRY_W  = 6;

    // Request codes; the two remaining encodings are unused and answer a miss.
    typedef enum logic [TYPE_W-1:0] {
        RT_ADD    = 3'd0,
        RT_R2V    = 3'd1,
        RT_V2R_RD = 3'd2,
        RT_V2R_WR = 3'd3,
        RT_DEL    = 3'd4,
        RT_FIRST  = 3'd5
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEARCH,
        S_DONE
    } fsm_t;

    typedef struct packed {
        logic [TYPE_W-1:0]  req_type;
        logic [RADDR_W-1:0] real_addr;
        logic [VADDR_W-1:0] virt_addr;
        logic [SIZE_W-1:0]  region_size;
    } req_t;

    typedef struct packed {
        logic               en;
        logic [RADDR_W-1:0] rbase;
        logic [VADDR_W-1:0] vbase;
        logic [SIZE_W-1:0]  size;
    } wr_t;

    // Search token handed from cell to cell, newest entry first.
    typedef struct packed {
        logic               busy;
        logic               found;
        logic [RADDR_W-1:0] addr;
        logic [ENTRY_W-1:0] idx;
    } link_t;

    typedef struct packed {
        status_t            status;
        logic [RADDR_W-1:0] addr;
        logic [ENTRY_W-1:0] idx;
    } res_t;

endpackage

`default_nettype wire

### src/rat_if.sv
`default_nettype none

interface rat_req_if;
    logic                        valid;
    logic                        ready;
    logic [rat_pkg::TYPE_W-1:0]  req_type;
    logic [rat_pkg::RADDR_W-1:0] real_addr;
    logic [rat_pkg::VADDR_W-1:0] virt_addr;
    logic [rat_pkg::SIZE_W-1:0]  region_size;

    modport source (output valid, req_type, real_addr, virt_addr, region_size, input ready);
    modport sink   (input valid, req_type, real_addr, virt_addr, region_size, output ready);
endinterface

interface rat_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [rat_pkg::STATUS_W-1:0] status;
    logic [rat_pkg::RADDR_W-1:0]  result_addr;
    logic [rat_pkg::ENTRY_W-1:0]  entry_index;

    modport source (output valid, status, result_addr, entry_index, input ready);
    modport sink   (input valid, status, result_addr, entry_index, output ready);
endinterface

`default_nettype wire

### src/rat_cell.sv
`default_nettype none

module rat_cell #(
    parameter int unsigned IDX        = 0,
    parameter int unsigned CNT_W      = 7,
    parameter int unsigned IDX_W      = 6,
    parameter int unsigned WORD_BYTES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rat_pkg::req_t       req,
    input  rat_pkg::wr_t        wr,
    input  logic [IDX_W-1:0]    wr_idx,
    input  logic [CNT_W-1:0]    count,
    input  rat_pkg::link_t      link_in,
    output rat_pkg::link_t      link_out
);
    import rat_pkg::*;

    logic [RADDR_W-1:0] rbase_reg;
    logic [VADDR_W-1:0] vbase_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [SIZE_W-1:0]  size_next;
    link_t              link_reg;
    link_t              link_next;

    logic               is_virt;
    logic [RADDR_W-1:0] addr_sel;
    logic [RADDR_W-1:0] base_sel;
    logic [RADDR_W:0]   diff;
    logic [RADDR_W-1:0] off;
    logic [RADDR_W-1:0] size_ext;
    logic               ge;
    logic               in_range;
    logic               fits;
    logic               del_range;
    logic               live;
    logic               want;
    logic               hit;
    logic [RADDR_W-1:0] other_base;
    logic [RADDR_W-1:0] sum;
    logic [RADDR_W-1:0] xlat;

    always_comb
    begin
        is_virt  = req.req_type != RT_R2V;
        addr_sel = is_virt ? {32'b0, req.virt_addr} : req.real_addr;
        base_sel = is_virt ? {32'b0, vbase_reg} : rbase_reg;
        // The borrow out of the wide subtraction tells whether the address lies below the base.
        diff     = {1'b0, addr_sel} - {1'b0, base_sel};
        ge       = !diff[RADDR_W];
        off      = diff[RADDR_W-1:0];
        size_ext = {32'b0, size_reg};
        in_range = ge && (off < size_ext);
        // Inside the region the offset stays below 2^32, so the sum cannot wrap.
        fits      = (off + RADDR_W'(WORD_BYTES)) < size_ext;
        del_range = ge && (off <= size_ext);
        live      = (size_reg != '0) && (count > CNT_W'(IDX));

        case (req.req_type)
            RT_R2V:    want = in_range && fits;
            RT_V2R_RD: want = in_range && fits;
            RT_V2R_WR: want = in_range;
            RT_DEL:    want = del_range;
            RT_FIRST:  want = (IDX == 0) && in_range && fits;
            default:   want = 1'b0;
        endcase

        hit        = link_in.busy && !link_in.found && live && want;
        other_base = is_virt ? rbase_reg : {32'b0, vbase_reg};
        sum        = other_base + {32'b0, off[31:0]};

        case (req.req_type)
            RT_R2V:  xlat = {32'b0, sum[31:0]};
            RT_DEL:  xlat = '0;
            default: xlat = sum;
        endcase

        link_next = link_in;
        if (hit)
        begin
            link_next.found = 1'b1;
            link_next.addr  = xlat;
            link_next.idx   = ENTRY_W'(IDX);
        end

        size_next = size_reg;
        if (wr.en && (wr_idx == IDX_W'(IDX)))
        begin
            size_next = wr.size;
        end
        else if (hit && (req.req_type == RT_DEL))
        begin
            size_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr_idx == IDX_W'(IDX)))
        begin
            rbase_reg <= wr.rbase;
            vbase_reg <= wr.vbase;
        end
        size_reg <= size_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

`default_nettype wire

### src/rat_ctrl.sv
`default_nettype none

module rat_ctrl #(
    parameter int unsigned REGIONS = 64,
    parameter int unsigned CNT_W   = 7,
    parameter int unsigned IDX_W   = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    rat_req_if.sink          req,
    rat_rsp_if.source        rsp,
    output rat_pkg::req_t    bcast,
    output rat_pkg::wr_t     wr,
    output logic [IDX_W-1:0] wr_idx,
    output logic [CNT_W-1:0] count,
    output rat_pkg::link_t   link_head,
    input  rat_pkg::link_t   link_tail
);
    import rat_pkg::*;

    fsm_t             state_reg;
    fsm_t             state_next;
    req_t             req_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    res_t             res_reg;
    res_t             res_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    res_t             out_reg;
    logic             accept;
    logic             load;
    logic             is_search;

    assign accept = req.valid && req.ready;
    assign load   = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        case (req_reg.req_type)
            RT_R2V, RT_V2R_RD, RT_V2R_WR, RT_DEL, RT_FIRST: is_search = 1'b1;
            default:                                        is_search = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = is_search ? S_SEARCH : S_DONE;
            end
            S_SEARCH:
            begin
                if (link_tail.busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready  = state_reg == S_IDLE;
        wr.en      = 1'b0;
        wr.rbase   = req_reg.real_addr;
        wr.vbase   = req_reg.virt_addr;
        wr.size    = req_reg.region_size;
        link_head  = '0;
        count_next = count_reg;
        res_next   = res_reg;

        case (state_reg)
            S_DISPATCH:
            begin
                if (req_reg.req_type == RT_ADD)
                begin
                    if (count_reg >= CNT_W'(REGIONS))
                    begin
                        res_next = '{status: ST_FULL, addr: '0, idx: '0};
                    end
                    else
                    begin
                        wr.en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        res_next   = '{status: ST_OK, addr: '0, idx: ENTRY_W'(count_reg)};
                    end
                end
                else if (is_search)
                begin
                    link_head.busy = 1'b1;
                end
                else
                begin
                    res_next = '{status: ST_MISS, addr: '0, idx: '0};
                end
            end
            S_SEARCH:
            begin
                if (link_tail.busy)
                begin
                    if (link_tail.found)
                    begin
                        res_next = '{status: ST_OK, addr: link_tail.addr, idx: link_tail.idx};
                    end
                    else
                    begin
                        res_next = '{status: ST_MISS, addr: '0, idx: '0};
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= '{req_type: req.req_type, real_addr: req.real_addr,
                         virt_addr: req.virt_addr, region_size: req.region_size};
        end
        res_reg <= res_next;
        if (load)
        begin
            out_reg <= res_reg;
        end
    end

    assign bcast           = req_reg;
    assign wr_idx          = count_reg[IDX_W-1:0];
    assign count           = count_reg;
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_reg.status;
    assign rsp.result_addr = out_reg.addr;
    assign rsp.entry_index = out_reg.idx;

    a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        link_tail.busy |-> state_reg == S_SEARCH)
        else $error("search token left the row of cells outside a search");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("entry count did not advance after an append");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(REGIONS))
        else $error("entry count exceeds table capacity");

    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) && link_tail.busy && !link_tail.found
        |=> (res_reg.status == ST_MISS) && (res_reg.addr == '0) && (res_reg.idx == '0))
        else $error("unmatched search did not give a clean miss");

endmodule

`default_nettype wire

### src/region_address_translation_table.sv
// Channel  Role    Payload
// req      sink    req_type, real_addr, virt_addr, region_size
// rsp      source  status, result_addr, entry_index
//
// One request is handled at a time. An add, or an unused request code, passes through the
// dispatch and done states to rsp; a lookup or delete also waits in the search state while the
// search token passes down the row of entry cells, one cell per cycle, newest entry first.
// The controller returns to idle, ready for a new request, at the edge that loads the previous
// result into the output register, even while that result waits for rsp.ready. Reset clears
// the entry count; entry contents stay undefined until written, and there is no clearing pass.
`default_nettype none

module region_address_translation_table #(
    parameter int unsigned REGIONS    = rat_pkg::REGIONS_DEF,
    parameter int unsigned WORD_BYTES = rat_pkg::WORD_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rat_req_if.sink   req,
    rat_rsp_if.source rsp
);
    import rat_pkg::*;

    localparam int unsigned CNT_W = $clog2(REGIONS + 1);
    localparam int unsigned IDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;

    req_t             bcast;
    wr_t              wr;
    logic [IDX_W-1:0] wr_idx;
    logic [CNT_W-1:0] count;
    // Element REGIONS feeds the highest-indexed cell; element 0 returns to the controller.
    link_t            link [REGIONS+1];

    rat_ctrl #(
        .REGIONS (REGIONS),
        .CNT_W   (CNT_W),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .bcast     (bcast),
        .wr        (wr),
        .wr_idx    (wr_idx),
        .count     (count),
        .link_head (link[REGIONS]),
        .link_tail (link[0])
    );

    for (genvar i = 0; i < REGIONS; i++)
    begin : g_cell
        rat_cell #(
            .IDX        (i),
            .CNT_W      (CNT_W),
            .IDX_W      (IDX_W),
            .WORD_BYTES (WORD_BYTES)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .req      (bcast),
            .wr       (wr),
            .wr_idx   (wr_idx),
            .count    (count),
            .link_in  (link[i+1]),
            .link_out (link[i])
        );
    end

endmodule

`default_nettype wire
